FILE: design/tsp_pkg.sv
// tsp_pkg: shared types, constants and the note pitch function
// used by every module of the tone score player but tsp_div; depends on nothing

package tsp_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int IFQ_DEPTH       = 4;
	localparam int CLK_W           = 25;
	localparam int IN_DATA_W       = 48;
	localparam int OUT_DATA_W      = 8;
	localparam logic [CLK_W-1:0] CLOCK_HZ_RST = 25'd8000000;
	// ms scaling: x / 1000 = (x >> 3) / 125, done as (y * ceil(2^36 / 125)) >> 36,
	// exact for every 29-bit y
	localparam logic [29:0] RECIP_125 = 30'd549755814;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_NOTE = 2'd1,
		KIND_TONE = 2'd2,
		KIND_STOP = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        zero_freq;
		logic [7:0]  note;
		logic [7:0]  note_length;
		logic [14:0] frequency;
		logic [15:0] duration_ms;
	} item_t;

	localparam logic [13:0] TONE_TABLE [12] = '{
		14'd8372, 14'd8870, 14'd9397, 14'd9956, 14'd10548, 14'd11175,
		14'd11840, 14'd12544, 14'd13290, 14'd14080, 14'd14917, 14'd15804
	};

	// pitch of a score note: table[n mod 12] >> ((131 - n) / 12)
	// n / 12 done as (n * 171) >> 11, exact over the note range
	function automatic logic [13:0] note_freq(input logic [6:0] n);
		logic [15:0] t1;
		logic [3:0]  q;
		logic [3:0]  r;
		logic [7:0]  m;
		logic [15:0] t2;
		logic [3:0]  sh;
		t1 = {9'b0, n} * 16'd171;
		q  = t1[14:11];
		r  = 4'(n - 7'(q) * 7'd12);
		m  = 8'd131 - {1'b0, n};
		t2 = {8'b0, m} * 16'd171;
		sh = t2[14:11];
		return TONE_TABLE[r] >> sh;
	endfunction

endpackage

FILE: design/tsp_div.sv
// tsp_div: restoring divider, one quotient bit per cycle
// 32-bit dividend by 16-bit divisor; no package dependency

module tsp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        ge;
	logic [15:0] rem_n;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign rem_n = ge ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], ge};
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: design/tsp_front.sv
// tsp_front: input word queue, classifies each accepted word
// depends on tsp_pkg

module tsp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [1:0]                  s_tuser,
	input  logic [tsp_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                        pop,
	output logic                        item_valid,
	output tsp_pkg::item_t              item
);

	localparam int PW = $clog2(tsp_pkg::IFQ_DEPTH);

	tsp_pkg::item_t fifo_q [tsp_pkg::IFQ_DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [PW:0]    cnt_q;
	tsp_pkg::item_t in_item;
	logic           push;

	always_comb begin
		in_item.kind        = tsp_pkg::kind_t'(s_tuser);
		in_item.note        = s_tdata[7:0];
		in_item.note_length = s_tdata[15:8];
		in_item.frequency   = s_tdata[30:16];
		in_item.duration_ms = s_tdata[46:31];
		in_item.zero_freq   = s_tdata[30:16] == 15'd0;
	end

	assign s_tready   = cnt_q != (PW+1)'(tsp_pkg::IFQ_DEPTH);
	assign push       = s_tvalid && s_tready;
	assign item_valid = cnt_q != '0;
	assign item       = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_item;
	end

endmodule

FILE: design/tsp_back.sv
// tsp_back: executes words in order: tone timer, score queue, tone setup
// depends on tsp_pkg and tsp_div

module tsp_back #(
	parameter int QUEUE_DEPTH = tsp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tsp_pkg::CLK_W-1:0]      cfg_wdata,
	input  logic                          item_valid,
	input  tsp_pkg::item_t                item,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tsp_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_DECODE, S_MUL, S_REC, S_DIVO, S_NORM
	} state_t;

	state_t state_q, state_d;
	logic [tsp_pkg::CLK_W-1:0] clock_hz_q;
	logic [15:0] mem [QUEUE_DEPTH];
	logic [15:0] rd_q;
	logic [IW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [31:0] toggles_q, toggles_d;
	logic [7:0]  top_q, top_d;
	logic [3:0]  pexp_q, pexp_d;
	logic [14:0] pcnt_q, pcnt_d;
	logic [7:0]  per_q, per_d;
	logic        spk_q, spk_d;
	logic        active_q, active_d;
	logic [15:0] f2_q, f2_d;
	logic [15:0] dur_q, dur_d;
	logic [24:0] ocr_q, ocr_d;
	logic [31:0] prod_q, prod_d;
	logic        m_valid_q, m_valid_d;
	logic [tsp_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

	logic        out_free, emit, rej, mem_we;
	logic [CW:0] tail_sum;
	logic [IW-1:0] tail;
	logic [IW-1:0] head_inc;
	logic        div_start, div_done;
	logic [31:0] div_dividend, div_q;
	logic [15:0] div_divisor;
	logic [14:0] span, pinc;
	logic [15:0] note_f2;
	logic [58:0] rprod;

	tsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	assign out_free = !m_valid_q || m_tready;
	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		IW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : IW'(tail_sum);
	assign head_inc = (32'(head_q) == QUEUE_DEPTH - 1) ? '0 : head_q + 1'b1;
	assign span     = 15'(1) << (pexp_q - 4'd1);
	assign pinc     = pcnt_q + 15'd1;
	assign note_f2  = {1'b0, tsp_pkg::note_freq(rd_q[14:8]), 1'b0};
	// (dur * f2) / 1000 by reciprocal multiplication
	assign rprod    = 59'(prod_q[31:3]) * 59'(tsp_pkg::RECIP_125);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		toggles_d = toggles_q;
		top_d     = top_q;
		pexp_d    = pexp_q;
		pcnt_d    = pcnt_q;
		per_d     = per_q;
		spk_d     = spk_q;
		active_d  = active_q;
		f2_d      = f2_q;
		dur_d     = dur_q;
		ocr_d     = ocr_q;
		prod_d    = prod_q;
		pop       = 1'b0;
		emit      = 1'b0;
		rej       = 1'b0;
		mem_we    = 1'b0;
		div_start = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			S_IDLE: if (item_valid && out_free) begin
				pop = 1'b1;
				case (item.kind)
					tsp_pkg::KIND_TICK: begin
						emit = 1'b1;
						if (active_q) begin
							if (pinc < span) begin
								pcnt_d = pinc;
							end else begin
								pcnt_d = '0;
								if (per_q != top_q) begin
									per_d = per_q + 8'd1;
								end else begin
									per_d = '0;
									if (toggles_q != '0) begin
										toggles_d = toggles_q - 32'd1;
										if (toggles_q != 32'd1) begin
											spk_d = !spk_q;
										end else begin
											spk_d    = 1'b0;
											active_d = 1'b0;
											if (count_q != '0) begin
												emit    = 1'b0;
												state_d = S_FETCH;
											end
										end
									end
								end
							end
						end
					end
					tsp_pkg::KIND_NOTE: begin
						if (32'(count_q) >= QUEUE_DEPTH) begin
							rej  = 1'b1;
							emit = 1'b1;
						end else begin
							mem_we  = 1'b1;
							count_d = count_q + 1'b1;
							if (!active_q) state_d = S_FETCH;
							else emit = 1'b1;
						end
					end
					tsp_pkg::KIND_TONE: begin
						if (item.zero_freq) begin
							rej  = 1'b1;
							emit = 1'b1;
						end else begin
							head_d  = '0;
							count_d = '0;
							f2_d    = {item.frequency, 1'b0};
							dur_d   = item.duration_ms;
							state_d = S_MUL;
						end
					end
					tsp_pkg::KIND_STOP: begin
						head_d    = '0;
						count_d   = '0;
						active_d  = 1'b0;
						toggles_d = '0;
						spk_d     = 1'b0;
						emit      = 1'b1;
					end
					default: emit = 1'b1;
				endcase
			end
			S_FETCH: state_d = S_DECODE;
			S_DECODE: begin
				head_d  = head_inc;
				count_d = count_q - 1'b1;
				if (rd_q[15]) begin
					// end of score mark
					head_d  = '0;
					count_d = '0;
					emit    = 1'b1;
					state_d = S_IDLE;
				end else if (note_f2 == '0) begin
					active_d = 1'b0;
					emit     = 1'b1;
					state_d  = S_IDLE;
				end else begin
					f2_d    = note_f2;
					dur_d   = {8'b0, rd_q[7:0]} * 16'd10;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				// divider works out ocr while the toggle count is scaled
				prod_d       = 32'(dur_q) * 32'(f2_q);
				div_start    = 1'b1;
				div_dividend = 32'(clock_hz_q);
				div_divisor  = f2_q;
				state_d      = S_REC;
			end
			S_REC: begin
				toggles_d = 32'(rprod[58:36]) + 32'd1;
				state_d   = S_DIVO;
			end
			S_DIVO: if (div_done) begin
				ocr_d   = div_q[24:0];
				pexp_d  = 4'd1;
				state_d = S_NORM;
			end
			S_NORM: begin
				if (ocr_q > 25'd255 && pexp_q < 4'd15) begin
					ocr_d  = ocr_q >> 1;
					pexp_d = pexp_q + 4'd1;
				end else begin
					if (ocr_q == '0) top_d = 8'd0;
					else if (ocr_q > 25'd256) top_d = 8'd255;
					else top_d = 8'(ocr_q - 25'd1);
					pcnt_d   = '0;
					per_d    = '0;
					active_d = 1'b1;
					emit     = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		m_valid_d = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_q);
		m_data_d  = emit ? {rej, 5'(count_d), active_d, spk_d} : m_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			clock_hz_q <= tsp_pkg::CLOCK_HZ_RST;
			head_q     <= '0;
			count_q    <= '0;
			toggles_q  <= '0;
			top_q      <= '0;
			pexp_q     <= 4'd1;
			pcnt_q     <= '0;
			per_q      <= '0;
			spk_q      <= 1'b0;
			active_q   <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			if (cfg_we) clock_hz_q <= cfg_wdata;
			head_q    <= head_d;
			count_q   <= count_d;
			toggles_q <= toggles_d;
			top_q     <= top_d;
			pexp_q    <= pexp_d;
			pcnt_q    <= pcnt_d;
			per_q     <= per_d;
			spk_q     <= spk_d;
			active_q  <= active_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		f2_q     <= f2_d;
		dur_q    <= dur_d;
		ocr_q    <= ocr_d;
		prod_q   <= prod_d;
		m_data_q <= m_data_d;
		rd_q     <= mem[head_q];
		if (mem_we) mem[tail] <= {item.note, item.note_length};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= QUEUE_DEPTH)
		else $error("score queue count beyond depth");
	a_speaker_idle: assert property (@(posedge clk) disable iff (!arst_n)
		spk_q |-> active_q)
		else $error("speaker high with no tone");
	a_period_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && state_q == S_IDLE |-> per_q <= top_q)
		else $error("period counter past top");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVO)
		else $error("divider finished outside setup");
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> out_free)
		else $error("word taken with result slot full");
`endif

endmodule

FILE: design/tone_score_player.sv
// tone_score_player: top level of the square-wave tone and score player
// depends on tsp_pkg, tsp_front, tsp_back (which uses tsp_div)
//
// channel   direction  contents
// s_*       in         one word: tuser = kind, tdata = note, note_length, frequency, duration_ms
// m_*       out        one result word per input word: speaker, playing, queued, rejected
// cfg_*     in         write of clock_hz, no read-back
//
// a tick, a refused word, a stop or a queued note with a tone sounding is answered from the idle state
// a direct tone setup runs one multiply, the divider for ocr
//   (the ms scaling by reciprocal multiply runs beside it), then up to 14 prescale steps
// a score note started (queued while idle, or next after a tone ends) adds fetch and decode
//   ahead of the tone setup; an end of score mark passes only fetch and decode
// a four-word input queue lets words arrive while a setup runs
// results wait in an output register; a stall there holds the back end only
// reset clears the score queue and timer at once, no clearing pass

module tone_score_player #(
	parameter int QUEUE_DEPTH = tsp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tsp_pkg::CLK_W-1:0]      cfg_wdata,   // clock_hz
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [1:0]                    s_tuser,     // kind
	// note[7:0], note_length[15:8], frequency[30:16], duration_ms[46:31], zero pad
	input  logic [tsp_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// speaker[0], playing[1], queued[6:2], rejected[7]
	output logic [tsp_pkg::OUT_DATA_W-1:0] m_tdata
);

	tsp_pkg::item_t item;
	logic           item_valid;
	logic           pop;

	// front end: queue and classify incoming words
	tsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.pop        (pop),
		.item_valid (item_valid),
		.item       (item)
	);

	// back end: timer, score queue and setup sequencer
	tsp_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
